[design/jsc_pkg.sv]
// Package for the JIS / subfont code converter.
// Holds the request and result payload types, command and status codes,
// and the constants for the divide-by-94 reciprocal. No dependencies.
`default_nettype none

package jsc_pkg;

	localparam logic CMD_TO_SUBFONT = 1'b0;
	localparam logic CMD_TO_JIS     = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_ROW  = 2'd1;
	localparam logic [1:0] ST_BAD_CELL = 2'd2;

	localparam logic [7:0] JIS_OFS = 8'h20;
	localparam int unsigned CELLS = 94;

	// floor(n / 94) == (n * RECIP_K) >> RECIP_SHIFT for every n below 11915
	localparam int unsigned RECIP_SHIFT = 20;
	localparam int unsigned RECIP_K     = ((1 << RECIP_SHIFT) + CELLS - 1) / CELLS;

	typedef struct packed {
		logic       cmd;
		logic [7:0] jis_row;
		logic [7:0] jis_cell;
		logic [5:0] subfont_in;
		logic [7:0] index_in;
	} jsc_req_t;

	typedef struct packed {
		logic [5:0] subfont_out;
		logic [7:0] index_out;
		logic [7:0] row_out;
		logic [7:0] cell_out;
		logic [1:0] status;
	} jsc_res_t;

endpackage

`default_nettype wire

[design/jis_subfont_code_converter_unit.sv]
// Top level of the JIS / subfont code converter: a three-stage pipeline.
// Depends on jsc_pkg for payload types, codes and constants.
`default_nettype none

// Converts one code per clock cycle in either direction. A request is
// taken whenever start is high; busy is always low, since the pipeline
// never stalls. Each result appears on res with done high for exactly one
// cycle, in request order. The receiver must take it in that cycle. The
// stages follow the subfont-to-JIS path: index computation, a reciprocal
// multiply for the divide by 94, then the quotient/remainder fix-up, each
// in its own stage.
module jis_subfont_code_converter_unit (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  jsc_pkg::jsc_req_t req,
	output logic             done,
	output jsc_pkg::jsc_res_t res
);
	import jsc_pkg::*;

	localparam int unsigned PROD_W = 28;
	localparam logic [13:0] RECIP  = 14'(RECIP_K);

	// ---------------- stage 1 logic ----------------
	logic       row_ok, cell_ok, small_row;
	logic [7:0] ku, ten;
	logic [5:0] kbase;
	logic [11:0] nj;
	logic [5:0] f1;
	logic [7:0] c1;
	logic [1:0] st1;
	logic       kanji1;

	logic       big_f, hi_f;
	logic [5:0] fbase;
	logic [7:0] rowv, cellv;

	always_comb begin
		ku        = req.jis_row - JIS_OFS;
		ten       = req.jis_cell - JIS_OFS;
		row_ok    = (req.jis_row >= 8'h21 && req.jis_row <= 8'h28) ||
		            (req.jis_row >= 8'h30 && req.jis_row <= 8'h74);
		cell_ok   = req.jis_cell >= 8'h21 && req.jis_cell <= 8'h7E;
		small_row = req.jis_row <= 8'h28;
		kbase     = (req.jis_row >= 8'h50) ? 6'(ku - 8'd48) : 6'(ku - 8'd16);
		nj        = 12'(kbase) * 12'(CELLS) + 12'(ten) - 12'd1;

		f1     = 6'd1;
		c1     = 8'd1;
		st1    = ST_OK;
		kanji1 = 1'b0;
		priority if (!row_ok) begin
			st1 = ST_BAD_ROW;
		end else if (!cell_ok) begin
			st1 = ST_BAD_CELL;
		end else if (small_row) begin
			unique case (ku)
				8'd1: begin
					f1 = 6'd1;
					c1 = ten;
				end
				8'd2: begin
					f1 = 6'd1;
					c1 = ten + 8'd100;
				end
				8'd3: begin
					f1 = 6'd2;
					c1 = req.jis_cell;
				end
				default: begin
					f1 = 6'(ku - 8'd1);
					c1 = ten;
				end
			endcase
		end else begin
			kanji1 = 1'b1;
		end

		big_f = req.subfont_in >= 6'd8;
		hi_f  = req.subfont_in >= 6'd20;
		fbase = hi_f ? req.subfont_in - 6'd20 : req.subfont_in - 6'd8;
		rowv  = 8'(req.subfont_in) + 8'd1;
		cellv = req.index_in;
		if (req.subfont_in == 6'd1) begin
			if (req.index_in >= 8'd100) begin
				rowv  = 8'd2;
				cellv = req.index_in - 8'd100;
			end else begin
				rowv  = 8'd1;
			end
		end else if (req.subfont_in == 6'd2) begin
			rowv  = 8'd3;
			cellv = req.index_in - 8'd32;
		end
	end

	logic        valid_s1, cmd_s1;
	logic [5:0]  f_s1;
	logic [7:0]  c_s1;
	logic [1:0]  st_s1;
	logic        kanji_s1, lvl2_s1;
	logic [11:0] nj_s1;
	logic        big_s1, hi_s1;
	logic [13:0] ns_s1;
	logic [7:0]  row_s1, cell_s1;

	// ---------------- stage 2 logic ----------------
	logic        valid_s2, cmd_s2;
	logic [5:0]  f_s2;
	logic [7:0]  c_s2;
	logic [1:0]  st_s2;
	logic        big_s2, hi_s2;
	logic [13:0] ns_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [7:0]  row_s2, cell_s2;

	// ---------------- stage 3 logic ----------------
	logic [7:0]  quot;
	logic [13:0] rem;
	jsc_res_t    res_next;

	always_comb begin
		quot = prod_s2[PROD_W-1:RECIP_SHIFT];
		rem  = ns_s2 - 14'(quot) * 14'(CELLS);

		res_next = '0;
		if (cmd_s2 == CMD_TO_JIS) begin
			if (big_s2) begin
				res_next.row_out  = quot + (hi_s2 ? 8'd48 : 8'd16) + JIS_OFS;
				res_next.cell_out = rem[7:0] + 8'd1 + JIS_OFS;
			end else begin
				res_next.row_out  = row_s2 + JIS_OFS;
				res_next.cell_out = cell_s2 + JIS_OFS;
			end
		end else begin
			res_next.subfont_out = f_s2;
			res_next.index_out   = c_s2;
			res_next.status      = st_s2;
		end
	end

	logic     valid_s3;
	jsc_res_t res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1   <= req.cmd;
		f_s1     <= f1;
		c_s1     <= c1;
		st_s1    <= st1;
		kanji_s1 <= kanji1;
		lvl2_s1  <= req.jis_row >= 8'h50;
		nj_s1    <= nj;
		big_s1   <= big_f;
		hi_s1    <= hi_f;
		ns_s1    <= {fbase, req.index_in};
		row_s1   <= rowv;
		cell_s1  <= cellv;

		cmd_s2  <= cmd_s1;
		st_s2   <= st_s1;
		// kanji rows: page number from the upper bits, index from the low byte
		if (kanji_s1) begin
			f_s2 <= 6'(nj_s1[11:8]) + (lvl2_s1 ? 6'd20 : 6'd8);
			c_s2 <= nj_s1[7:0];
		end else begin
			f_s2 <= f_s1;
			c_s2 <= c_s1;
		end
		big_s2  <= big_s1;
		hi_s2   <= hi_s1;
		ns_s2   <= ns_s1;
		prod_s2 <= PROD_W'(ns_s1) * PROD_W'(RECIP);
		row_s2  <= row_s1;
		cell_s2 <= cell_s1;

		res_s3 <= res_next;
	end

	assign busy = 1'b0;
	assign done = valid_s3;
	assign res  = res_s3;

endmodule

`default_nettype wire
